// ----- rtl/core/rfifo_pkg.sv -----
`timescale 1ns / 1ps
package rfifo_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int WORD_WIDTH_DEF = 32;
	localparam int CNT_W          = 32;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_RESP
	} state_t;

	typedef struct packed {
		logic take;
		logic push_ok;
		logic push_drop;
		logic pop_ok;
		logic pop_empty;
		logic load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} dp_stat_t;

endpackage

// ----- rtl/core/rfifo_ram.sv -----
`timescale 1ns / 1ps
module rfifo_ram #(
	parameter int WIDTH = rfifo_pkg::WORD_WIDTH_DEF,
	parameter int DEPTH = rfifo_pkg::DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/rfifo_ctrl.sv -----
`timescale 1ns / 1ps
module rfifo_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	input  rfifo_pkg::dp_stat_t   stat,
	output rfifo_pkg::ctrl_cmd_t  cmd
);
	import rfifo_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   is_push;
	logic   is_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// decode the request kind; unused code behaves as a query
	always_comb begin
		is_push = 1'b0;
		is_pop  = 1'b0;
		unique case (s_tuser)
			OP_PUSH: is_push = 1'b1;
			OP_POP:  is_pop  = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.take      = 1'b1;
					cmd.push_ok   = is_push && !stat.full;
					cmd.push_drop = is_push && stat.full;
					cmd.pop_ok    = is_pop && !stat.empty;
					cmd.pop_empty = is_pop && stat.empty;
					state_d       = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d  = S_RESP;
			end
			S_RESP: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ----- rtl/core/rfifo_dp.sv -----
`timescale 1ns / 1ps
module rfifo_dp #(
	parameter int DEPTH      = rfifo_pkg::DEPTH_DEF,
	parameter int WORD_WIDTH = rfifo_pkg::WORD_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rfifo_pkg::ctrl_cmd_t         cmd,
	output rfifo_pkg::dp_stat_t          stat,
	input  logic [WORD_WIDTH-1:0]        push_data,
	output logic [1:0]                   status,
	output logic [WORD_WIDTH-1:0]        pop_data,
	output logic [$clog2(DEPTH+1)-1:0]   occupancy,
	output logic [rfifo_pkg::CNT_W-1:0]  drop_count,
	output logic [rfifo_pkg::CNT_W-1:0]  push_count,
	output logic [$clog2(DEPTH+1)-1:0]   occ_peak
);
	import rfifo_pkg::*;

	localparam int ADDR_W = $clog2(DEPTH);
	localparam int PTR_W  = $clog2(2 * DEPTH);
	localparam int OCC_W  = $clog2(DEPTH + 1);
	localparam int SPAN   = 2 * DEPTH;

	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      drops_q;
	logic [CNT_W-1:0]      pushes_q;
	logic [OCC_W-1:0]      peak_q;
	status_t               status_q;
	logic                  popped_q;

	logic [PTR_W:0]        diff;
	logic [OCC_W-1:0]      fill;
	logic [OCC_W-1:0]      fill_inc;
	logic [PTR_W-1:0]      wr_ptr_nxt;
	logic [PTR_W-1:0]      rd_ptr_nxt;
	logic [ADDR_W-1:0]     wr_slot;
	logic [ADDR_W-1:0]     rd_slot;
	logic [WORD_WIDTH-1:0] ram_rdata;

	// pointers run modulo twice the depth so full and empty differ
	always_comb begin
		if (wr_ptr_q >= rd_ptr_q) begin
			diff = {1'b0, wr_ptr_q} - {1'b0, rd_ptr_q};
		end else begin
			diff = {1'b0, wr_ptr_q} + (PTR_W + 1)'(SPAN) - {1'b0, rd_ptr_q};
		end
		fill     = OCC_W'(diff);
		fill_inc = fill + OCC_W'(1);

		wr_ptr_nxt = (wr_ptr_q == PTR_W'(SPAN - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
		rd_ptr_nxt = (rd_ptr_q == PTR_W'(SPAN - 1)) ? '0 : rd_ptr_q + PTR_W'(1);

		wr_slot = (wr_ptr_q >= PTR_W'(DEPTH)) ? ADDR_W'(wr_ptr_q - PTR_W'(DEPTH))
			: ADDR_W'(wr_ptr_q);
		rd_slot = (rd_ptr_q >= PTR_W'(DEPTH)) ? ADDR_W'(rd_ptr_q - PTR_W'(DEPTH))
			: ADDR_W'(rd_ptr_q);

		stat.full  = (fill == OCC_W'(DEPTH));
		stat.empty = (fill == '0);
	end

	rfifo_ram #(
		.WIDTH (WORD_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.push_ok),
		.waddr (wr_slot),
		.wdata (push_data),
		.re    (cmd.pop_ok),
		.raddr (rd_slot),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			drops_q  <= '0;
			pushes_q <= '0;
			peak_q   <= '0;
			status_q <= STAT_OK;
			popped_q <= 1'b0;
		end else begin
			if (cmd.push_ok) begin
				wr_ptr_q <= wr_ptr_nxt;
				pushes_q <= pushes_q + CNT_W'(1);
				if (fill_inc > peak_q) begin
					peak_q <= fill_inc;
				end
			end
			if (cmd.push_drop) begin
				drops_q <= drops_q + CNT_W'(1);
			end
			if (cmd.pop_ok) begin
				rd_ptr_q <= rd_ptr_nxt;
			end
			if (cmd.take) begin
				popped_q <= cmd.pop_ok;
				if (cmd.push_drop) begin
					status_q <= STAT_FULL;
				end else if (cmd.pop_empty) begin
					status_q <= STAT_EMPTY;
				end else begin
					status_q <= STAT_OK;
				end
			end
		end
	end

	// result register, loaded once the memory word has arrived
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status     <= status_q;
			pop_data   <= popped_q ? ram_rdata : '0;
			occupancy  <= fill;
			drop_count <= drops_q;
			push_count <= pushes_q;
			occ_peak   <= peak_q;
		end
	end

endmodule

// ----- rtl/core/ring_fifo_with_drop_and_watermark.sv -----
`timescale 1ns / 1ps
// ring fifo of message words with drop counter and high-water mark
//
// input channel s_*: one request per handshake; s_tuser holds the kind
// (push, pop, status query; the spare code acts as a query), s_tdata
// holds the word to store on a push
// output channel m_*: exactly one result per request, in request order;
// m_tuser holds the status (ok, full on push, empty on pop), m_tdata the
// popped word (zero unless a pop succeeded), occupancy, drop and push
// counters and the high-water mark, all as they stand after the request
//
// timing: a request is taken in the idle cycle, which also issues the read
// of the ring memory (registered read port); the next cycle loads the result
// register, and the result is offered in the response state; one request
// is in flight at a time; a stalled receiver holds the result in place and
// s_tready stays low until the result is taken
//
// reset clears pointers, counters and the high-water mark; the memory is
// not cleared, since a pop only reads slots written by earlier pushes
module ring_fifo_with_drop_and_watermark #(
	parameter int DEPTH      = rfifo_pkg::DEPTH_DEF,
	parameter int WORD_WIDTH = rfifo_pkg::WORD_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// push_data, zero padded to whole bytes
	input  logic [((WORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	// op
	input  logic [1:0]                            s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// pop_data, occupancy, drop_count, push_count, occ_peak, zero padded
	output logic [((WORD_WIDTH + 2 * $clog2(DEPTH + 1) + 2 * rfifo_pkg::CNT_W + 7) / 8) * 8 - 1:0]
		m_tdata,
	// status
	output logic [1:0]                            m_tuser
);
	import rfifo_pkg::*;

	localparam int OCC_W   = $clog2(DEPTH + 1);
	localparam int OUT_W   = ((WORD_WIDTH + 2 * OCC_W + 2 * CNT_W + 7) / 8) * 8;

	ctrl_cmd_t             cmd;
	dp_stat_t              stat;
	logic [WORD_WIDTH-1:0] pop_data;
	logic [OCC_W-1:0]      occupancy;
	logic [CNT_W-1:0]      drop_count;
	logic [CNT_W-1:0]      push_count;
	logic [OCC_W-1:0]      occ_peak;

	// request sequencing and handshakes
	rfifo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// pointers, counters, ring memory and result register
	rfifo_dp #(
		.DEPTH      (DEPTH),
		.WORD_WIDTH (WORD_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.push_data  (s_tdata[WORD_WIDTH-1:0]),
		.status     (m_tuser),
		.pop_data   (pop_data),
		.occupancy  (occupancy),
		.drop_count (drop_count),
		.push_count (push_count),
		.occ_peak   (occ_peak)
	);

	// pack the result fields, first field in the lowest bits
	assign m_tdata = OUT_W'({occ_peak, push_count, drop_count, occupancy, pop_data});

endmodule

// ----- test/ring_fifo_with_drop_and_watermark_test.sv -----
`timescale 1ns / 1ps
module ring_fifo_with_drop_and_watermark_test;
	import rfifo_pkg::*;

	localparam int DEPTH     = DEPTH_DEF;
	localparam int WW        = WORD_WIDTH_DEF;
	localparam int OCC_W     = $clog2(DEPTH + 1);
	localparam int PTR_W     = $clog2(2 * DEPTH);
	localparam int S_TD_W    = ((WW + 7) / 8) * 8;
	localparam int M_TD_W    = ((WW + 2 * OCC_W + 2 * CNT_W + 7) / 8) * 8;
	localparam int RAND_REQS = 1000;
	localparam int CALM_REQS = 150;
	localparam int STUCK_MAX = 4000;

	// spare request kind, behaves like a status query
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef enum int {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN
	} mix_t;

	typedef struct packed {
		status_t          status;
		logic [WW-1:0]    word;
		logic [OCC_W-1:0] fill;
		logic [CNT_W-1:0] drops;
		logic [CNT_W-1:0] pushes;
		logic [OCC_W-1:0] peak;
	} fifo_result_t;

	// one line of the directed table; reps repeats the request with varied data
	typedef struct packed {
		logic [1:0]    op;
		logic [WW-1:0] data;
		logic [5:0]    reps;
		logic          typed;
		fifo_result_t  want;
	} stim_row_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	// push_data
	logic [S_TD_W-1:0]   s_tdata  = '0;
	// op
	logic [1:0]          s_tuser  = OP_QUERY;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	// pop_data, occupancy, drop_count, push_count, occ_peak
	logic [M_TD_W-1:0]   m_tdata;
	// status
	logic [1:0]          m_tuser;

	ring_fifo_with_drop_and_watermark uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow copy of the ring and its counters
	logic [WW-1:0]    ring_words [DEPTH];
	logic [PTR_W-1:0] wr_pos = '0;
	logic [PTR_W-1:0] rd_pos = '0;
	logic [CNT_W-1:0] drop_total = '0;
	logic [CNT_W-1:0] push_total = '0;
	logic [OCC_W-1:0] peak_fill = '0;

	fifo_result_t pending_results [$];
	stim_row_t    stim_rows [$];

	int  errors = 0;
	int  checked = 0;
	int  full_refusals = 0;
	int  empty_pops = 0;
	int  good_pops = 0;
	bit  calm = 1'b0;
	bit  quiet = 1'b0;
	int  rx_hold = 0;
	int  stuck = 0;

	function automatic fifo_result_t mk_res(status_t st, logic [WW-1:0] w, int f, int d,
		int p, int pk);
		fifo_result_t r;
		r.status = st;
		r.word   = w;
		r.fill   = OCC_W'(f);
		r.drops  = CNT_W'(d);
		r.pushes = CNT_W'(p);
		r.peak   = OCC_W'(pk);
		return r;
	endfunction

	// advance the shadow fifo by one request and return what the block must answer
	function automatic fifo_result_t next_fifo_result(logic [1:0] op, logic [WW-1:0] data);
		fifo_result_t     r;
		logic [PTR_W-1:0] fill;
		fill     = wr_pos - rd_pos;
		r.status = STAT_OK;
		r.word   = '0;
		if (op == OP_PUSH) begin
			if (fill >= PTR_W'(DEPTH)) begin
				drop_total++;
				r.status = STAT_FULL;
				full_refusals++;
			end else begin
				ring_words[wr_pos[PTR_W-2:0]] = data;
				wr_pos++;
				push_total++;
				if (OCC_W'(fill + 1'b1) > peak_fill)
					peak_fill = OCC_W'(fill + 1'b1);
			end
		end else if (op == OP_POP) begin
			if (fill == '0) begin
				r.status = STAT_EMPTY;
				empty_pops++;
			end else begin
				r.word = ring_words[rd_pos[PTR_W-2:0]];
				rd_pos++;
				good_pops++;
			end
		end
		r.fill   = OCC_W'(wr_pos - rd_pos);
		r.drops  = drop_total;
		r.pushes = push_total;
		r.peak   = peak_fill;
		return r;
	endfunction

	task automatic add_row(logic [1:0] op, logic [WW-1:0] data, int reps, bit typed,
		fifo_result_t want);
		stim_row_t row;
		row.op    = op;
		row.data  = data;
		row.reps  = 6'(reps);
		row.typed = typed;
		row.want  = want;
		stim_rows.push_back(row);
	endtask

	task automatic sender_gap();
		if (!calm && !quiet && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	// hold one request on the bus until it is taken; the expectation is either
	// typed in by the caller or worked out by the shadow fifo
	task automatic send_request(logic [1:0] op, logic [WW-1:0] data, bit typed,
		fifo_result_t want);
		fifo_result_t predicted;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= S_TD_W'(data);
		do @(posedge clk); while (!s_tready);
		predicted = next_fifo_result(op, data);
		pending_results.push_back(typed ? want : predicted);
	endtask

	function automatic logic [1:0] pick_op(mix_t mix);
		int r;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_FILL:  return (r < 70) ? OP_PUSH : (r < 90) ? OP_POP : (r < 97) ? OP_QUERY : OP_SPARE;
			MIX_DRAIN: return (r < 20) ? OP_PUSH : (r < 92) ? OP_POP : (r < 98) ? OP_QUERY : OP_SPARE;
			default:   return (r < 45) ? OP_PUSH : (r < 90) ? OP_POP : (r < 97) ? OP_QUERY : OP_SPARE;
		endcase
	endfunction

	function automatic logic [WW-1:0] pick_word();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return '1;
			default: return WW'($urandom);
		endcase
	endfunction

	// receiver: random stall bursts, none once the run is calm
	always @(posedge clk) begin
		if (rx_hold != 0)
			rx_hold--;
		else if (!calm && !quiet && $urandom_range(0, 11) == 0)
			rx_hold = $urandom_range(1, 13);
		m_tready <= (rx_hold == 0);
	end

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// result checker: every taken result against the oldest expectation
	always @(posedge clk) begin
		fifo_result_t got;
		fifo_result_t want;
		if (m_tvalid && m_tready) begin
			got.status = status_t'(m_tuser);
			got.word   = m_tdata[WW-1:0];
			got.fill   = m_tdata[WW +: OCC_W];
			got.drops  = m_tdata[WW + OCC_W +: CNT_W];
			got.pushes = m_tdata[WW + OCC_W + CNT_W +: CNT_W];
			got.peak   = m_tdata[WW + OCC_W + 2 * CNT_W +: OCC_W];
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result with none expected, status %0h data %0h", $time,
					m_tuser, m_tdata);
			end else begin
				want = pending_results.pop_front();
				checked++;
				check_field("status", 64'(want.status), 64'(got.status));
				check_field("pop_data", 64'(want.word), 64'(got.word));
				check_field("occupancy", 64'(want.fill), 64'(got.fill));
				check_field("drop_count", 64'(want.drops), 64'(got.drops));
				check_field("push_count", 64'(want.pushes), 64'(got.pushes));
				check_field("occ_peak", 64'(want.peak), 64'(got.peak));
			end
		end
	end

	// watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stuck = 0;
		else
			stuck++;
		if (stuck >= STUCK_MAX) begin
			$display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
				STUCK_MAX, pending_results.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		fifo_result_t none;
		stim_row_t    row;
		mix_t         mix;
		none = '0;

		// directed table: reset state, spare code, word extremes, full and empty edges
		add_row(OP_QUERY, '0, 1, 1, mk_res(STAT_OK, '0, 0, 0, 0, 0));
		add_row(OP_POP, '1, 1, 1, mk_res(STAT_EMPTY, '0, 0, 0, 0, 0));
		add_row(OP_SPARE, '1, 1, 1, mk_res(STAT_OK, '0, 0, 0, 0, 0));
		add_row(OP_PUSH, '0, 1, 1, mk_res(STAT_OK, '0, 1, 0, 1, 1));
		add_row(OP_PUSH, '1, 1, 1, mk_res(STAT_OK, '0, 2, 0, 2, 2));
		add_row(OP_POP, '0, 1, 1, mk_res(STAT_OK, '0, 1, 0, 2, 2));
		add_row(OP_POP, '0, 1, 1, mk_res(STAT_OK, '1, 0, 0, 2, 2));
		add_row(OP_POP, '0, 1, 1, mk_res(STAT_EMPTY, '0, 0, 0, 2, 2));
		add_row(OP_PUSH, WW'(32'h8000_0001), DEPTH, 0, none);
		add_row(OP_PUSH, '1, 1, 1, mk_res(STAT_FULL, '0, DEPTH, 1, DEPTH + 2, DEPTH));
		add_row(OP_PUSH, '0, 1, 1, mk_res(STAT_FULL, '0, DEPTH, 2, DEPTH + 2, DEPTH));
		add_row(OP_QUERY, '1, 1, 1, mk_res(STAT_OK, '0, DEPTH, 2, DEPTH + 2, DEPTH));
		add_row(OP_POP, '0, DEPTH, 0, none);
		add_row(OP_POP, '0, 1, 1, mk_res(STAT_EMPTY, '0, 0, 2, DEPTH + 2, DEPTH));
		add_row(OP_SPARE, '0, 1, 1, mk_res(STAT_OK, '0, 0, 2, DEPTH + 2, DEPTH));
		add_row(OP_PUSH, WW'(32'h5555_5555), 1, 0, none);
		add_row(OP_POP, '0, 1, 0, none);
		add_row(OP_PUSH, WW'(32'hAAAA_AAAA), 1, 0, none);
		add_row(OP_POP, '0, 1, 0, none);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			row = stim_rows[i];
			for (int r = 0; r < row.reps; r++) begin
				sender_gap();
				send_request(row.op, row.data ^ WW'({4{8'(r)}}), row.typed, row.want);
			end
		end

		// random part: the request mix swings between filling and draining so the
		// ring keeps hitting both edges and the pointers wrap many times
		mix = MIX_FILL;
		for (int i = 0; i < RAND_REQS; i++) begin
			if (i % 40 == 0) begin
				mix   = mix_t'($urandom_range(0, 2));
				quiet = ($urandom_range(0, 3) == 0);
			end
			if (i == RAND_REQS - CALM_REQS)
				calm = 1'b1;
			if (i == RAND_REQS / 2) begin
				// hold off until the block has answered everything
				s_tvalid <= 1'b0;
				do @(posedge clk); while (pending_results.size() != 0);
			end
			sender_gap();
			send_request(pick_op(mix), pick_word(), 0, none);
		end

		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (8) @(posedge clk);

		$display("checked %0d results: %0d good pops, %0d empty pops, %0d refused pushes,",
			checked, good_pops, empty_pops, full_refusals);
		$display("%0d pushes taken in total, high-water mark %0d", push_total, peak_fill);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
